// ----- rtl/bers_pkg.sv -----
// Shared types, constants and lookup tables of the bearing error RSS block.
package bers_pkg;

  localparam int SIGMA_BITS_DEF = 20;
  localparam int OUT_W          = 20;
  localparam int CFG_W          = 16;
  localparam int SNR_W          = 11;
  localparam int REG_IDX_W      = 3;
  localparam int TERM_ST        = 8;   // stages in bers_term
  localparam int RSS_ST         = 3;   // stages in bers_rss
  localparam int X_W            = 36;  // sigma * mantissa
  localparam int TERM_W         = 38;  // unsaturated SNR term

  localparam logic [12:0] E_BIAS  = 13'd2400;  // keeps the exponent nonnegative
  localparam logic [4:0]  QI_ZERO = 5'd12;     // decade index of 10^0
  localparam logic [4:0]  K_LAST  = 5'd6;      // deeper divisions round to zero

  typedef enum logic [REG_IDX_W-1:0] {
    REG_METHOD     = 3'd0,
    REG_SNR_SIGMA  = 3'd1,
    REG_SNR_REF    = 3'd2,
    REG_CALIB      = 3'd3,
    REG_ATTITUDE   = 3'd4,
    REG_MP_LOS     = 3'd5,
    REG_MP_NLOS    = 3'd6,
    REG_MIXTURE    = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [CFG_W-1:0] method_sigma;
    logic [CFG_W-1:0] snr_ref_sigma;
    logic [SNR_W-1:0] snr_ref_tenths;
    logic [CFG_W-1:0] calibration_sigma;
    logic [CFG_W-1:0] attitude_sigma;
    logic [CFG_W-1:0] multipath_los_sigma;
    logic [CFG_W-1:0] multipath_nlos_sigma;
    logic [CFG_W-1:0] mixture_sigma;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    method_sigma:         16'd0,
    snr_ref_sigma:        16'd0,
    snr_ref_tenths:       11'd100,
    calibration_sigma:    16'd0,
    attitude_sigma:       16'd0,
    multipath_los_sigma:  16'd0,
    multipath_nlos_sigma: 16'd0,
    mixture_sigma:        16'd0
  };

  // round(10^(a/10) * 2^16)
  function automatic logic [18:0] pow_a(input logic [3:0] a);
    logic [18:0] r;
    unique case (a)
      4'd0:    r = 19'd65536;
      4'd1:    r = 19'd82505;
      4'd2:    r = 19'd103868;
      4'd3:    r = 19'd130762;
      4'd4:    r = 19'd164619;
      4'd5:    r = 19'd207243;
      4'd6:    r = 19'd260904;
      4'd7:    r = 19'd328458;
      4'd8:    r = 19'd413504;
      4'd9:    r = 19'd520571;
      default: r = 19'd0;
    endcase
    return r;
  endfunction

  // round(10^(b/200) * 2^16)
  function automatic logic [16:0] pow_b(input logic [4:0] b);
    logic [16:0] r;
    unique case (b)
      5'd0:    r = 17'd65536;
      5'd1:    r = 17'd66295;
      5'd2:    r = 17'd67063;
      5'd3:    r = 17'd67839;
      5'd4:    r = 17'd68625;
      5'd5:    r = 17'd69419;
      5'd6:    r = 17'd70223;
      5'd7:    r = 17'd71036;
      5'd8:    r = 17'd71859;
      5'd9:    r = 17'd72691;
      5'd10:   r = 17'd73533;
      5'd11:   r = 17'd74384;
      5'd12:   r = 17'd75245;
      5'd13:   r = 17'd76117;
      5'd14:   r = 17'd76998;
      5'd15:   r = 17'd77890;
      5'd16:   r = 17'd78792;
      5'd17:   r = 17'd79704;
      5'd18:   r = 17'd80627;
      5'd19:   r = 17'd81561;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // 10^q for the upper decades
  function automatic logic [16:0] pow10(input logic [2:0] q);
    logic [16:0] r;
    unique case (q)
      3'd0:    r = 17'd1;
      3'd1:    r = 17'd10;
      3'd2:    r = 17'd100;
      3'd3:    r = 17'd1000;
      3'd4:    r = 17'd10000;
      3'd5:    r = 17'd100000;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // 10^k / 2, rounding offset of the lower decades
  function automatic logic [20:0] half_k(input logic [3:0] k);
    logic [20:0] r;
    unique case (k)
      4'd1:    r = 21'd5;
      4'd2:    r = 21'd50;
      4'd3:    r = 21'd500;
      4'd4:    r = 21'd5000;
      4'd5:    r = 21'd50000;
      4'd6:    r = 21'd500000;
      default: r = 21'd0;
    endcase
    return r;
  endfunction

  // ceil(2^s / 10^k), exact for 21-bit dividends
  function automatic logic [21:0] recip_k(input logic [3:0] k);
    logic [21:0] r;
    unique case (k)
      4'd1:    r = 22'd3355444;
      4'd2:    r = 22'd2684355;
      4'd3:    r = 22'd2147484;
      4'd4:    r = 22'd3435974;
      4'd5:    r = 22'd2748780;
      4'd6:    r = 22'd2199024;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

  // s = 21 + ceil(log2(10^k))
  function automatic logic [5:0] rshift_k(input logic [3:0] k);
    logic [5:0] r;
    unique case (k)
      4'd1:    r = 6'd25;
      4'd2:    r = 6'd28;
      4'd3:    r = 6'd31;
      4'd4:    r = 6'd35;
      4'd5:    r = 6'd38;
      4'd6:    r = 6'd41;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/bers_term.sv -----
// SNR term: exponent split, mantissa tables, decade scaling and saturation.
module bers_term #(
  parameter int SIGMA_BITS = bers_pkg::SIGMA_BITS_DEF
) (
  input  logic                              clk,
  input  logic [bers_pkg::TERM_ST-1:0]      en,
  input  bers_pkg::cfg_t                    cfg,
  input  logic [bers_pkg::SNR_W-1:0]        snr_tenths,
  input  logic                              direct_path,
  input  logic                              mixture_present,
  output logic [SIGMA_BITS-1:0]             term,
  output logic                              term_sat,
  output logic                              los,
  output logic                              mix
);

  localparam int TS = bers_pkg::TERM_ST;
  localparam int XW = bers_pkg::X_W;
  localparam int TW = bers_pkg::TERM_W;

  // flags ride along the stages
  logic [TS-1:0] los_q;
  logic [TS-1:0] mix_q;

  // stage registers
  logic [11:0]   e1;
  logic [7:0]    t2;
  logic [4:0]    b2;
  logic [4:0]    qi3;
  logic [3:0]    a3;
  logic [4:0]    b3;
  logic [35:0]   prod4;
  logic [4:0]    qi4;
  logic [19:0]   m5;
  logic [4:0]    qi5;
  logic [XW-1:0] x6;
  logic [4:0]    qi6;
  logic [34:0]   hi7;
  logic [34:0]   lo7;
  logic [42:0]   rp7;
  logic          pos7;
  logic          zero7;
  logic [3:0]    k7;

  // combinational
  logic [9:0]    snr_c;
  logic [12:0]   e_sum;
  logic [23:0]   t_prod;
  logic [11:0]   b_full;
  logic [15:0]   q_prod;
  logic [7:0]    a_full;
  logic [35:0]   prod_c;
  logic [35:0]   m_sum;
  logic [XW-1:0] x_c;
  logic [4:0]    qn_full;
  logic [4:0]    k_full;
  logic [16:0]   p10;
  logic [20:0]   nd;
  logic [34:0]   hi_c;
  logic [34:0]   lo_c;
  logic [42:0]   rp_c;
  logic [53:0]   pos_sum;
  logic [42:0]   rp_sh;
  logic [TW-1:0] term_full;
  logic          over;

  // readings below 0 dB count as 0 dB
  assign snr_c  = snr_tenths[bers_pkg::SNR_W-1] ? 10'd0 : snr_tenths[9:0];
  assign e_sum  = {{2{cfg.snr_ref_tenths[bers_pkg::SNR_W-1]}}, cfg.snr_ref_tenths}
                  + bers_pkg::E_BIAS - {3'b000, snr_c};

  // e / 20 and e % 20 by reciprocal
  assign t_prod = {12'd0, e1} * 24'd3277;
  assign b_full = e1 - ({4'd0, t_prod[23:16]} * 12'd20);

  // t / 10 and t % 10
  assign q_prod = {8'd0, t2} * 16'd205;
  assign a_full = t2 - ({3'd0, q_prod[15:11]} * 8'd10);

  assign prod_c = {17'd0, bers_pkg::pow_a(a3)} * {19'd0, bers_pkg::pow_b(b3)};
  assign m_sum  = prod4 + 36'd32768;
  assign x_c    = {20'd0, cfg.snr_ref_sigma} * {16'd0, m5};

  // upper decades: x * 10^q, split in two partial products
  assign qn_full = qi6 - bers_pkg::QI_ZERO;
  assign p10     = bers_pkg::pow10(qn_full[2:0]);
  assign hi_c    = {17'd0, x6[35:18]} * {18'd0, p10};
  assign lo_c    = {17'd0, x6[17:0]} * {18'd0, p10};

  // lower decades: round(x / (10^k * 2^16)) with an exact reciprocal
  assign k_full = bers_pkg::QI_ZERO - qi6;
  assign nd     = {1'b0, x6[35:16]} + bers_pkg::half_k(k_full[3:0]);
  assign rp_c   = {22'd0, nd} * {21'd0, bers_pkg::recip_k(k_full[3:0])};

  assign pos_sum = {1'b0, hi7, 18'd0} + {19'd0, lo7} + 54'd32768;
  assign rp_sh   = rp7 >> bers_pkg::rshift_k(k7);

  always_comb begin
    if (pos7) begin
      term_full = pos_sum[53:16];
    end else if (zero7) begin
      term_full = '0;
    end else begin
      term_full = {17'd0, rp_sh[20:0]};
    end
  end

  assign over = |term_full[TW-1:SIGMA_BITS];

  always_ff @(posedge clk) begin
    los_q <= (en & {los_q[TS-2:0], direct_path}) | (~en & los_q);
    mix_q <= (en & {mix_q[TS-2:0], mixture_present}) | (~en & mix_q);
    if (en[0]) begin
      e1 <= e_sum[11:0];
    end
    if (en[1]) begin
      t2 <= t_prod[23:16];
      b2 <= b_full[4:0];
    end
    if (en[2]) begin
      qi3 <= q_prod[15:11];
      a3  <= a_full[3:0];
      b3  <= b2;
    end
    if (en[3]) begin
      prod4 <= prod_c;
      qi4   <= qi3;
    end
    if (en[4]) begin
      m5  <= m_sum[35:16];
      qi5 <= qi4;
    end
    if (en[5]) begin
      x6  <= x_c;
      qi6 <= qi5;
    end
    if (en[6]) begin
      hi7   <= hi_c;
      lo7   <= lo_c;
      rp7   <= rp_c;
      pos7  <= (qi6 >= bers_pkg::QI_ZERO);
      zero7 <= (k_full > bers_pkg::K_LAST);
      k7    <= k_full[3:0];
    end
    if (en[7]) begin
      term     <= over ? '1 : term_full[SIGMA_BITS-1:0];
      term_sat <= over;
    end
  end

  assign los = los_q[TS-1];
  assign mix = mix_q[TS-1];

endmodule

// ----- rtl/bers_rss.sv -----
// Squares of the six error terms and their registered adder tree.
module bers_rss #(
  parameter int SIGMA_BITS = bers_pkg::SIGMA_BITS_DEF
) (
  input  logic                          clk,
  input  logic [bers_pkg::RSS_ST-1:0]   en,
  input  bers_pkg::cfg_t                cfg,
  input  logic [SIGMA_BITS-1:0]         term_in,
  input  logic                          sat_in,
  input  logic                          los,
  input  logic                          mix,
  output logic [2*SIGMA_BITS-1:0]       rad,
  output logic                          over,
  output logic [SIGMA_BITS-1:0]         term_out,
  output logic                          sat_out
);

  localparam int SB = SIGMA_BITS;
  localparam int SW = 2*SB + 3;
  localparam logic [SW-1:0] LIM    = {{(SW-SB){1'b0}}, {SB{1'b1}}};
  localparam logic [SW-1:0] LIM_SQ = LIM * LIM;

  logic [2*SB-1:0] sq_t;
  logic [31:0]     sq_m;
  logic [31:0]     sq_c;
  logic [31:0]     sq_a;
  logic [31:0]     sq_p;
  logic [31:0]     sq_x;
  logic [2*SB:0]   p0;
  logic [32:0]     p1;
  logic [32:0]     p2;
  logic [SB-1:0]   term_q [2];
  logic [1:0]      sat_q;

  logic [bers_pkg::CFG_W-1:0] mp;
  logic [bers_pkg::CFG_W-1:0] mx;
  logic [SW-1:0]              total;

  assign mp    = los ? cfg.multipath_los_sigma : cfg.multipath_nlos_sigma;
  assign mx    = mix ? cfg.mixture_sigma : '0;
  assign total = {2'b00, p0} + {{(SW-33){1'b0}}, p1} + {{(SW-33){1'b0}}, p2};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sq_t      <= {{SB{1'b0}}, term_in} * {{SB{1'b0}}, term_in};
      sq_m      <= {16'd0, cfg.method_sigma} * {16'd0, cfg.method_sigma};
      sq_c      <= {16'd0, cfg.calibration_sigma} * {16'd0, cfg.calibration_sigma};
      sq_a      <= {16'd0, cfg.attitude_sigma} * {16'd0, cfg.attitude_sigma};
      sq_p      <= {16'd0, mp} * {16'd0, mp};
      sq_x      <= {16'd0, mx} * {16'd0, mx};
      term_q[0] <= term_in;
      sat_q[0]  <= sat_in;
    end
    if (en[1]) begin
      p0        <= {1'b0, sq_t} + {{(2*SB-31){1'b0}}, sq_m};
      p1        <= {1'b0, sq_c} + {1'b0, sq_a};
      p2        <= {1'b0, sq_p} + {1'b0, sq_x};
      term_q[1] <= term_q[0];
      sat_q[1]  <= sat_q[0];
    end
    if (en[2]) begin
      rad      <= total[2*SB-1:0];
      over     <= (total > LIM_SQ);
      term_out <= term_q[1];
      sat_out  <= sat_q[1];
    end
  end

endmodule

// ----- rtl/bers_sqrt.sv -----
// Pipelined digit-by-digit square root with round-to-nearest output stage.
module bers_sqrt #(
  parameter int SIGMA_BITS = bers_pkg::SIGMA_BITS_DEF
) (
  input  logic                      clk,
  input  logic [SIGMA_BITS:0]       en,
  input  logic [2*SIGMA_BITS-1:0]   rad,
  input  logic                      over_in,
  input  logic [SIGMA_BITS-1:0]     term_in,
  input  logic                      sat_in,
  output logic [SIGMA_BITS-1:0]     total,
  output logic [SIGMA_BITS-1:0]     term,
  output logic                      sat
);

  localparam int SB    = SIGMA_BITS;
  localparam int RW    = SB + 2;
  localparam int TAG_W = SB + 2;

  logic [RW-1:0]    rem_q  [SB];
  logic [SB-1:0]    root_q [SB];
  logic [2*SB-1:0]  n_q    [SB];
  logic [TAG_W-1:0] tag_q  [SB];

  for (genvar i = 0; i < SB; i++) begin : g_stage
    logic [RW-1:0]    rem_prev;
    logic [SB-1:0]    root_prev;
    logic [2*SB-1:0]  n_prev;
    logic [TAG_W-1:0] tag_prev;
    logic [RW+1:0]    rem_sh;
    logic [RW+1:0]    trial;
    logic [RW+1:0]    diff;
    logic             take;

    if (i == 0) begin : g_first
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign n_prev    = rad;
      assign tag_prev  = {over_in, sat_in, term_in};
    end else begin : g_next
      assign rem_prev  = rem_q[i-1];
      assign root_prev = root_q[i-1];
      assign n_prev    = n_q[i-1];
      assign tag_prev  = tag_q[i-1];
    end

    // bring down two radicand bits, try root*4+1
    assign rem_sh = {rem_prev, n_prev[2*SB-1 -: 2]};
    assign trial  = {2'b00, root_prev, 2'b01};
    assign take   = (rem_sh >= trial);
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk) begin
      if (en[i]) begin
        rem_q[i]  <= take ? diff[RW-1:0] : rem_sh[RW-1:0];
        root_q[i] <= {root_prev[SB-2:0], take};
        n_q[i]    <= {n_prev[2*SB-3:0], 2'b00};
        tag_q[i]  <= tag_prev;
      end
    end
  end

  logic [RW-1:0]    rem_f;
  logic [SB-1:0]    root_f;
  logic [TAG_W-1:0] tag_f;
  logic             round_up;

  assign rem_f    = rem_q[SB-1];
  assign root_f   = root_q[SB-1];
  assign tag_f    = tag_q[SB-1];
  // remainder above the root means the true root is past the half point
  assign round_up = (rem_f > {2'b00, root_f});

  always_ff @(posedge clk) begin
    if (en[SB]) begin
      total <= tag_f[SB+1] ? '1 : root_f + {{(SB-1){1'b0}}, round_up};
      term  <= tag_f[SB-1:0];
      sat   <= tag_f[SB] | tag_f[SB+1];
    end
  end

endmodule

// ----- rtl/bearing_error_rss_top.sv -----
// Top level of the bearing error RSS block: config registers and pipeline control.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one item per cycle when ready: an SNR
//   reading in tenths of a dB plus the line-of-sight and mixture flags. Output
//   channel (out_valid/out_ready) returns one item for each input item, in order: the
//   saturated SNR sigma term, the root-sum-square total and a saturation flag.
//   Config registers are written through cfg_we/cfg_index/cfg_data, one per
//   cycle, and must only change while the pipeline is empty.
//   The pipeline has 8 stages for the SNR term, 3 for the squares and sum, one
//   per root bit in the square root and one for rounding. Throughput is one item
//   per cycle while the output is not stalled; the square root
//   costs depth, not rate.
//   Every stage has a valid bit. A stage loads whenever it is empty or the stage
//   after it moves, so a stalled receiver holds the output item while bubbles
//   upstream keep filling; in_ready drops only when every stage is full.
//   Reset clears all valid bits and loads the register defaults (reference SNR
//   10 dB, all sigmas zero).
module bearing_error_rss_top #(
  parameter int SIGMA_BITS = bers_pkg::SIGMA_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bers_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [bers_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bers_pkg::SNR_W-1:0]          snr_tenths,
  input  logic                                direct_path,
  input  logic                                mixture_present,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bers_pkg::OUT_W-1:0]          snr_term,
  output logic [bers_pkg::OUT_W-1:0]          total_sigma,
  output logic                                saturated
);

  localparam int SB    = SIGMA_BITS;
  localparam int TS    = bers_pkg::TERM_ST;
  localparam int RS    = bers_pkg::RSS_ST;
  localparam int NS    = TS + RS + SB + 1;
  localparam int OW    = bers_pkg::OUT_W;

  bers_pkg::cfg_t cfg;

  // pipeline occupancy and load enables
  logic [NS-1:0] v;
  logic [NS-1:0] v_next;
  logic [NS-1:0] en;
  logic          in_fire;
  logic          out_fire;

  always_comb begin
    en[NS-1] = ~v[NS-1] | out_ready;
    for (int j = NS - 2; j >= 0; j--) begin
      en[j] = ~v[j] | en[j+1];
    end
  end

  assign v_next    = (en & {v[NS-2:0], in_valid}) | (~en & v);
  assign in_ready  = en[0];
  assign out_valid = v[NS-1];
  assign in_fire   = in_valid & in_ready;
  assign out_fire  = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v   <= '0;
      cfg <= bers_pkg::CFG_RESET;
    end else begin
      v <= v_next;
      if (cfg_we) begin
        unique case (bers_pkg::reg_index_t'(cfg_index))
          bers_pkg::REG_METHOD:    cfg.method_sigma         <= cfg_data;
          bers_pkg::REG_SNR_SIGMA: cfg.snr_ref_sigma        <= cfg_data;
          bers_pkg::REG_SNR_REF:   cfg.snr_ref_tenths       <= cfg_data[bers_pkg::SNR_W-1:0];
          bers_pkg::REG_CALIB:     cfg.calibration_sigma    <= cfg_data;
          bers_pkg::REG_ATTITUDE:  cfg.attitude_sigma       <= cfg_data;
          bers_pkg::REG_MP_LOS:    cfg.multipath_los_sigma  <= cfg_data;
          bers_pkg::REG_MP_NLOS:   cfg.multipath_nlos_sigma <= cfg_data;
          bers_pkg::REG_MIXTURE:   cfg.mixture_sigma        <= cfg_data;
        endcase
      end
    end
  end

  // SNR term
  logic [SB-1:0] term_a;
  logic          sat_a;
  logic          los_a;
  logic          mix_a;

  bers_term #(.SIGMA_BITS(SB)) u_term (
    .clk             (clk),
    .en              (en[TS-1:0]),
    .cfg             (cfg),
    .snr_tenths      (snr_tenths),
    .direct_path     (direct_path),
    .mixture_present (mixture_present),
    .term            (term_a),
    .term_sat        (sat_a),
    .los             (los_a),
    .mix             (mix_a)
  );

  // sum of squares
  logic [2*SB-1:0] rad_b;
  logic            over_b;
  logic [SB-1:0]   term_b;
  logic            sat_b;

  bers_rss #(.SIGMA_BITS(SB)) u_rss (
    .clk      (clk),
    .en       (en[TS+RS-1:TS]),
    .cfg      (cfg),
    .term_in  (term_a),
    .sat_in   (sat_a),
    .los      (los_a),
    .mix      (mix_a),
    .rad      (rad_b),
    .over     (over_b),
    .term_out (term_b),
    .sat_out  (sat_b)
  );

  // square root and rounding
  logic [SB-1:0] total_int;
  logic [SB-1:0] term_int;
  logic          sat_int;

  bers_sqrt #(.SIGMA_BITS(SB)) u_sqrt (
    .clk     (clk),
    .en      (en[NS-1:TS+RS]),
    .rad     (rad_b),
    .over_in (over_b),
    .term_in (term_b),
    .sat_in  (sat_b),
    .total   (total_int),
    .term    (term_int),
    .sat     (sat_int)
  );

  // output fields carry the low bits; zero-extended for narrow sigmas
  logic [SB+OW-1:0] total_ext;
  logic [SB+OW-1:0] term_ext;

  assign total_ext   = {{OW{1'b0}}, total_int};
  assign term_ext    = {{OW{1'b0}}, term_int};
  assign total_sigma = total_ext[OW-1:0];
  assign snr_term    = term_ext[OW-1:0];
  assign saturated   = sat_int;

  // input side closes only when every stage holds an item and the output stalls
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low with room in the pipeline");

  // items are neither lost nor duplicated across the stages
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ($countones(v) == $past($countones(v)) + $past(int'(in_fire))
                                 - $past(int'(out_fire))))
    else $error("pipeline occupancy does not match accepted and delivered items");

  // the rounded root of a sum that contains term^2 cannot be below term
  a_total_ge_term: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !sat_int) |-> (total_int >= term_int))
    else $error("total below SNR term without saturation");

endmodule

// ----- bench/tb_bearing_error_rss_top.sv -----
// Self-checking bench for bearing_error_rss_top: bit-exact predictor, scoreboard, random flow.
module tb_bearing_error_rss_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIGMA_BITS = bers_pkg::SIGMA_BITS_DEF;
  localparam int OUT_W      = bers_pkg::OUT_W;
  localparam int CFG_W      = bers_pkg::CFG_W;
  localparam int SNR_W      = bers_pkg::SNR_W;
  localparam int REG_IDX_W  = bers_pkg::REG_IDX_W;
  // SNR term stages + square/sum stages + one per root bit + rounding
  localparam int PIPE_DEPTH = SIGMA_BITS + 12;

  // Q16 mantissa tables: 10^(a/10) per 2 dB and 10^(b/200) per 0.1 dB
  localparam longint unsigned DB2_STEP [10] = '{
    65536, 82505, 103868, 130762, 164619, 207243, 260904, 328458, 413504, 520571
  };
  localparam longint unsigned TENTH_STEP [20] = '{
    65536, 66295, 67063, 67839, 68625, 69419, 70223, 71036, 71859, 72691,
    73533, 74384, 75245, 76117, 76998, 77890, 78792, 79704, 80627, 81561
  };
  localparam longint unsigned DECADE [12] = '{
    64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000,
    64'd10000000, 64'd100000000, 64'd1000000000, 64'd10000000000,
    64'd100000000000
  };

  typedef struct {
    logic [OUT_W-1:0] snr_term;
    logic [OUT_W-1:0] total_sigma;
    logic             saturated;
  } sigma_result_t;

  // DUT ports; every input has a known value from time zero
  logic                 clk             = 1'b0;
  logic                 rst             = 1'b1;
  logic                 cfg_we          = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index       = bers_pkg::REG_METHOD;
  logic [CFG_W-1:0]     cfg_data        = '0;
  logic                 in_valid        = 1'b0;
  logic                 in_ready;
  logic [SNR_W-1:0]     snr_tenths      = '0;
  logic                 direct_path     = 1'b0;
  logic                 mixture_present = 1'b0;
  logic                 out_valid;
  logic                 out_ready       = 1'b0;
  logic [OUT_W-1:0]     snr_term;
  logic [OUT_W-1:0]     total_sigma;
  logic                 saturated;

  // Bench state
  bers_pkg::cfg_t budget_cfg = bers_pkg::CFG_RESET;   // mirror of the register file
  sigma_result_t  pending_sigmas[$];                  // predicted results, oldest first
  sigma_result_t  oldest;
  int             send_idle_pct = 11;
  int             recv_idle_pct = 51;
  int             mismatches    = 0;

  bearing_error_rss_top u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .snr_tenths      (snr_tenths),
    .direct_path     (direct_path),
    .mixture_present (mixture_present),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .snr_term        (snr_term),
    .total_sigma     (total_sigma),
    .saturated       (saturated)
  );

  always #4 clk = ~clk;

  // Hard stop at 2 ms; it covers the whole run many times over.
  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end

  // Error budget for one reading under the current register settings.
  function automatic sigma_result_t predict_sigma(input logic [SNR_W-1:0] snr_raw,
                                                  input logic los, input logic mix);
    longint unsigned lim, mant, x, term, den, sum, mp, mx, root, rem, probe;
    int              snr, snr_ref, e, q, f;
    sigma_result_t   r;
    lim     = (64'd1 << SIGMA_BITS) - 1;
    snr     = $signed(snr_raw);
    snr_ref = $signed(budget_cfg.snr_ref_tenths);
    r.saturated = 1'b0;
    // readings below 0 dB count as 0 dB
    if (snr < 0) snr = 0;
    // bias keeps the exponent positive so / and % behave like floor
    e = snr_ref - snr + 2400;
    q = e / 200 - 12;
    f = e % 200;
    mant = (DB2_STEP[f / 20] * TENTH_STEP[f % 20] + 64'd32768) >> 16;
    x    = longint'(budget_cfg.snr_ref_sigma) * mant;
    if (q >= 0) begin
      term = (x * DECADE[q] + 64'd32768) >> 16;
    end else begin
      den  = DECADE[-q] << 16;
      term = (x + den / 2) / den;
    end
    if (term > lim) begin
      term = lim;
      r.saturated = 1'b1;
    end
    mp  = los ? longint'(budget_cfg.multipath_los_sigma)
              : longint'(budget_cfg.multipath_nlos_sigma);
    mx  = mix ? longint'(budget_cfg.mixture_sigma) : 64'd0;
    // no 64-bit overflow is possible with 16-bit sigmas and a 20-bit term
    sum = longint'(budget_cfg.method_sigma) * longint'(budget_cfg.method_sigma)
        + term * term
        + longint'(budget_cfg.calibration_sigma) * longint'(budget_cfg.calibration_sigma)
        + longint'(budget_cfg.attitude_sigma) * longint'(budget_cfg.attitude_sigma)
        + mp * mp + mx * mx;
    if (sum > lim * lim) begin
      root = lim;
      r.saturated = 1'b1;
    end else begin
      // digit-by-digit integer root, then round to nearest
      root  = 0;
      rem   = sum;
      probe = 64'd1 << 62;
      while (probe > rem) probe >>= 2;
      while (probe != 0) begin
        if (rem >= root + probe) begin
          rem  -= root + probe;
          root  = (root >> 1) + probe;
        end else begin
          root >>= 1;
        end
        probe >>= 2;
      end
      if (sum - root * root > root) root++;
    end
    r.snr_term    = OUT_W'(term);
    r.total_sigma = OUT_W'(root);
    return r;
  endfunction

  // One register write; caller lowers cfg_we after the last one.
  task automatic put_reg(input bers_pkg::reg_index_t idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  // Writes all eight registers; only called with the pipeline empty.
  task automatic write_config(input bers_pkg::cfg_t c);
    put_reg(bers_pkg::REG_METHOD,    c.method_sigma);
    put_reg(bers_pkg::REG_SNR_SIGMA, c.snr_ref_sigma);
    put_reg(bers_pkg::REG_SNR_REF,
            {{(CFG_W-SNR_W){c.snr_ref_tenths[SNR_W-1]}}, c.snr_ref_tenths});
    put_reg(bers_pkg::REG_CALIB,     c.calibration_sigma);
    put_reg(bers_pkg::REG_ATTITUDE,  c.attitude_sigma);
    put_reg(bers_pkg::REG_MP_LOS,    c.multipath_los_sigma);
    put_reg(bers_pkg::REG_MP_NLOS,   c.multipath_nlos_sigma);
    put_reg(bers_pkg::REG_MIXTURE,   c.mixture_sigma);
    cfg_we     <= 1'b0;
    budget_cfg  = c;
  endtask

  // Offers one reading; starts and ends on a falling edge.
  task automatic send_reading(input logic [SNR_W-1:0] snr, input logic los,
                              input logic mix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    snr_tenths      <= snr;
    direct_path     <= los;
    mixture_present <= mix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_sigmas.push_back(predict_sigma(snr, los, mix));
    @(negedge clk);
  endtask

  // Stops the sender and waits for every predicted item to come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_sigmas.size() != 0) @(negedge clk);
  endtask

  function automatic logic [CFG_W-1:0] rand_sigma();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2, 3:    return CFG_W'($urandom_range(4000));
      default: return CFG_W'($urandom_range(65535));
    endcase
  endfunction

  function automatic bers_pkg::cfg_t rand_config();
    bers_pkg::cfg_t c;
    c.method_sigma         = rand_sigma();
    c.snr_ref_sigma        = rand_sigma();
    c.calibration_sigma    = rand_sigma();
    c.attitude_sigma       = rand_sigma();
    c.multipath_los_sigma  = rand_sigma();
    c.multipath_nlos_sigma = rand_sigma();
    c.mixture_sigma        = rand_sigma();
    // reference mostly in the documented range, sometimes any 11-bit pattern
    case ($urandom_range(9))
      0:       c.snr_ref_tenths = SNR_W'(-1024);
      1:       c.snr_ref_tenths = SNR_W'(1023);
      2:       c.snr_ref_tenths = SNR_W'($urandom_range(2047));
      default: c.snr_ref_tenths = SNR_W'(int'($urandom_range(1000)) - 400);
    endcase
    return c;
  endfunction

  // Register defaults: every sigma zero, so both outputs are zero.
  task automatic test_reset_defaults();
    send_reading(SNR_W'(0), 1'b0, 1'b0);
    send_reading(SNR_W'(-400), 1'b1, 1'b1);
    send_reading(SNR_W'(600), 1'b0, 1'b1);
  endtask

  // SNR across its range, negative readings included, with all flag combinations.
  task automatic test_snr_sweep();
    bers_pkg::cfg_t c;
    c = '{method_sigma: 16'd1000, snr_ref_sigma: 16'd2000, snr_ref_tenths: 11'd100,
          calibration_sigma: 16'd500, attitude_sigma: 16'd300,
          multipath_los_sigma: 16'd400, multipath_nlos_sigma: 16'd1200,
          mixture_sigma: 16'd800};
    wait_for_results();
    write_config(c);
    send_reading(SNR_W'(-1024), 1'b0, 1'b0);
    send_reading(SNR_W'(-400),  1'b1, 1'b0);
    send_reading(SNR_W'(-1),    1'b0, 1'b1);
    send_reading(SNR_W'(0),     1'b1, 1'b1);
    send_reading(SNR_W'(1),     1'b0, 1'b0);
    send_reading(SNR_W'(100),   1'b1, 1'b0);
    send_reading(SNR_W'(599),   1'b0, 1'b1);
    send_reading(SNR_W'(600),   1'b1, 1'b1);
    send_reading(SNR_W'(1023),  1'b0, 1'b0);
  endtask

  // Term and total saturation, and terms that round down to zero.
  task automatic test_saturation();
    bers_pkg::cfg_t c;
    // every sigma at full scale, highest reference
    c = '{method_sigma: '1, snr_ref_sigma: '1, snr_ref_tenths: SNR_W'(1023),
          calibration_sigma: '1, attitude_sigma: '1, multipath_los_sigma: '1,
          multipath_nlos_sigma: '1, mixture_sigma: '1};
    wait_for_results();
    write_config(c);
    send_reading(SNR_W'(0),    1'b1, 1'b1);
    send_reading(SNR_W'(1023), 1'b0, 1'b1);
    send_reading(SNR_W'(-1),   1'b1, 1'b0);
    // lowest reference: deepest decade divisions
    c = '{method_sigma: '0, snr_ref_sigma: '1, snr_ref_tenths: SNR_W'(-1024),
          calibration_sigma: '0, attitude_sigma: '0, multipath_los_sigma: '0,
          multipath_nlos_sigma: '0, mixture_sigma: '0};
    wait_for_results();
    write_config(c);
    send_reading(SNR_W'(1023), 1'b0, 1'b0);
    send_reading(SNR_W'(0),    1'b1, 1'b0);
    // SNR term alone overflows the output width
    c = '{method_sigma: '0, snr_ref_sigma: 16'd2000, snr_ref_tenths: SNR_W'(600),
          calibration_sigma: '0, attitude_sigma: '0, multipath_los_sigma: '0,
          multipath_nlos_sigma: '0, mixture_sigma: '1};
    wait_for_results();
    write_config(c);
    send_reading(SNR_W'(-400), 1'b0, 1'b0);
    send_reading(SNR_W'(400),  1'b0, 1'b1);
    send_reading(SNR_W'(450),  1'b1, 1'b1);
    send_reading(SNR_W'(600),  1'b1, 1'b0);
  endtask

  // Random readings under a series of random settings at one idling mix.
  task automatic test_random_traffic(input int n_items, input int send_pct,
                                     input int recv_pct);
    logic [SNR_W-1:0] snr;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int n = 0; n < n_items; n++) begin
      // new settings every 120 items; the drain is also the full-flush pause
      if (n % 120 == 0) begin
        wait_for_results();
        write_config(rand_config());
      end
      if ($urandom_range(99) < 85) snr = SNR_W'(int'($urandom_range(1000)) - 400);
      else                         snr = SNR_W'($urandom_range(2047));
      send_reading(snr, 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  // Receiver backpressure, changed on the falling edge only.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Scoreboard: each accepted output item against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_sigmas.size() == 0) begin
        $error("unexpected result item: snr_term %0d total_sigma %0d saturated %0d",
               snr_term, total_sigma, saturated);
        mismatches++;
      end else begin
        oldest = pending_sigmas.pop_front();
        if (snr_term !== oldest.snr_term) begin
          $error("snr_term: expected %0d, got %0d", oldest.snr_term, snr_term);
          mismatches++;
        end
        if (total_sigma !== oldest.total_sigma) begin
          $error("total_sigma: expected %0d, got %0d", oldest.total_sigma, total_sigma);
          mismatches++;
        end
        if (saturated !== oldest.saturated) begin
          $error("saturated: expected %0d, got %0d", oldest.saturated, saturated);
          mismatches++;
        end
      end
    end
  end

  // Test sequence
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_snr_sweep();
    test_saturation();
    test_random_traffic(600, 11, 51);
    test_random_traffic(600, 51, 11);
    test_random_traffic(600, 0, 0);
    wait_for_results();
    // a full pipeline depth more, to catch stray items
    repeat (PIPE_DEPTH + 8) @(negedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- bearing_error_rss_top.f -----
rtl/bers_pkg.sv
rtl/bers_term.sv
rtl/bers_rss.sv
rtl/bers_sqrt.sv
rtl/bearing_error_rss_top.sv
bench/tb_bearing_error_rss_top.sv
